[src/catavg_pkg.sv]
// Shared constants for the calibrated converter trimmed-average block.
`default_nettype none
package catavg_pkg;
  localparam int DEF_SAMPLES = 5;

  localparam int FULL_SCALE = 4095;
  localparam int MV_PER_V = 1000;
  localparam int CHAN_SCALE = FULL_SCALE * MV_PER_V;

  localparam int ADC_W = 12;
  localparam int RES_W = 32;
  localparam int ERR_W = 2;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_REF_ZERO = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SPAN_ZERO = 2'd2;

  localparam logic [1:0] MODE_TEMP = 2'd0;
  localparam logic [1:0] MODE_SUPPLY = 2'd1;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_REF_CAL = 3'd1;
  localparam logic [2:0] REG_REF_OFFSET = 3'd2;
  localparam logic [2:0] REG_TCAL_LOW = 3'd3;
  localparam logic [2:0] REG_TCAL_HIGH = 3'd4;
  localparam logic [2:0] REG_CAL_MV = 3'd5;
  localparam logic [2:0] REG_TPT_LOW = 3'd6;
  localparam logic [2:0] REG_TPT_HIGH = 3'd7;

  localparam logic [1:0] RST_MODE = 2'd0;
  localparam logic [11:0] RST_REF_CAL = 12'd1671;
  localparam logic [11:0] RST_REF_OFFSET = 12'd0;
  localparam logic [11:0] RST_TCAL_LOW = 12'd670;
  localparam logic [11:0] RST_TCAL_HIGH = 12'd860;
  localparam logic [11:0] RST_CAL_MV = 12'd3000;
  localparam logic [8:0] RST_TPT_LOW = 9'd30;
  localparam logic [8:0] RST_TPT_HIGH = 9'd130;
endpackage
`default_nettype wire

[src/catavg_if.sv]
// Valid/ready channel interfaces for converter pairs and trimmed-mean results.
`default_nettype none
interface catavg_in_if;
  logic valid;
  logic ready;
  logic [catavg_pkg::ADC_W-1:0] ref_reading;
  logic [catavg_pkg::ADC_W-1:0] sample_reading;
  modport source (output valid, output ref_reading, output sample_reading, input ready);
  modport sink (input valid, input ref_reading, input sample_reading, output ready);
endinterface

interface catavg_out_if;
  logic valid;
  logic ready;
  logic signed [catavg_pkg::RES_W-1:0] result_q16;
  logic [catavg_pkg::ERR_W-1:0] error_code;
  modport source (output valid, output result_q16, output error_code, input ready);
  modport sink (input valid, input result_q16, input error_code, output ready);
endinterface
`default_nettype wire

[src/calibrated_adc_trimmed_average_core.sv]
// Top level: calibrated converter front end with trimmed-mean averaging.
//
//  channel     dir   handshake        payload
//  sample_in   in    valid/ready      ref_reading[11:0], sample_reading[11:0]
//  result_out  out   valid/ready      result_q16[31:0] signed, error_code[1:0]
//  apb         in    psel/penable     paddr[4:0], pwdata/prdata[31:0]
//
// Each converter pair is taken in, then makes up to four passes through the
// shared multiplier and 57 steps of the one-bit restoring divider. A batch
// end adds another divider pass for the trimmed mean unless the batch holds
// an error. A result sits in the output register until taken; a new batch
// waits before emitting if that register is still full.
// Reset (synchronous, active high) restores registers and clears accumulators.
`default_nettype none
module calibrated_adc_trimmed_average_core #(
  parameter int SAMPLES = catavg_pkg::DEF_SAMPLES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  catavg_in_if.sink        sample_in,
  catavg_out_if.source     result_out
);
  localparam int CW = $clog2(SAMPLES + 1);
  localparam int NW = 56;         // signed numerator
  localparam int DENW = 37;       // signed denominator
  localparam int QW = NW + 1;     // rounded dividend 2n+d
  localparam int DDW = DENW + 1;  // divisor 2d
  localparam int ICW = $clog2(QW + 1);
  localparam int TRIM = SAMPLES - 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  // configuration registers
  logic [1:0]  mode;
  logic [11:0] ref_cal_word, ref_offset, temp_cal_low, temp_cal_high, cal_supply_mv;
  logic [8:0]  temp_point_low, temp_point_high;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= catavg_pkg::RST_MODE;
      ref_cal_word    <= catavg_pkg::RST_REF_CAL;
      ref_offset      <= catavg_pkg::RST_REF_OFFSET;
      temp_cal_low    <= catavg_pkg::RST_TCAL_LOW;
      temp_cal_high   <= catavg_pkg::RST_TCAL_HIGH;
      cal_supply_mv   <= catavg_pkg::RST_CAL_MV;
      temp_point_low  <= catavg_pkg::RST_TPT_LOW;
      temp_point_high <= catavg_pkg::RST_TPT_HIGH;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        catavg_pkg::REG_MODE:       mode            <= pwdata[1:0];
        catavg_pkg::REG_REF_CAL:    ref_cal_word    <= pwdata[11:0];
        catavg_pkg::REG_REF_OFFSET: ref_offset      <= pwdata[11:0];
        catavg_pkg::REG_TCAL_LOW:   temp_cal_low    <= pwdata[11:0];
        catavg_pkg::REG_TCAL_HIGH:  temp_cal_high   <= pwdata[11:0];
        catavg_pkg::REG_CAL_MV:     cal_supply_mv   <= pwdata[11:0];
        catavg_pkg::REG_TPT_LOW:    temp_point_low  <= pwdata[8:0];
        catavg_pkg::REG_TPT_HIGH:   temp_point_high <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      catavg_pkg::REG_MODE:       prdata = {30'd0, mode};
      catavg_pkg::REG_REF_CAL:    prdata = {20'd0, ref_cal_word};
      catavg_pkg::REG_REF_OFFSET: prdata = {20'd0, ref_offset};
      catavg_pkg::REG_TCAL_LOW:   prdata = {20'd0, temp_cal_low};
      catavg_pkg::REG_TCAL_HIGH:  prdata = {20'd0, temp_cal_high};
      catavg_pkg::REG_CAL_MV:     prdata = {20'd0, cal_supply_mv};
      catavg_pkg::REG_TPT_LOW:    prdata = {23'd0, temp_point_low};
      catavg_pkg::REG_TPT_HIGH:   prdata = {23'd0, temp_point_high};
      default:                    prdata = 32'd0;
    endcase
  end

  // derived calibration terms
  logic signed [13:0] r_word;   // ref_cal_word + trim
  logic signed [12:0] span;     // C2 - C1
  logic signed [9:0]  dt;       // T2 - T1
  logic               is_temp, is_supply;

  assign r_word = $signed({2'b00, ref_cal_word}) + {{2{ref_offset[11]}}, $signed(ref_offset)};
  assign span   = $signed({1'b0, temp_cal_high}) - $signed({1'b0, temp_cal_low});
  assign dt     = {temp_point_high[8], $signed(temp_point_high)}
                - {temp_point_low[8], $signed(temp_point_low)};
  assign is_temp   = (mode == catavg_pkg::MODE_TEMP);
  assign is_supply = (mode == catavg_pkg::MODE_SUPPLY);

  // sequencer and datapath registers
  logic [2:0]  state;
  logic [1:0]  step;
  logic [11:0] ref_q, adc_q;
  logic [catavg_pkg::ERR_W-1:0] cur_err;
  logic        is_final;
  logic signed [27:0] t_a, t_b;
  logic signed [NW-1:0] num;
  logic signed [DENW-1:0] den;
  logic [QW-1:0]  dvd;      // dividend shifting out, quotient shifting in
  logic [DDW-1:0] dsr;
  logic [DDW-1:0] rem;
  logic [ICW-1:0] div_cnt;
  logic        neg;
  logic signed [31:0] val;

  // batch accumulators
  logic [CW-1:0]      sample_count;
  logic signed [39:0] running_sum;
  logic signed [31:0] running_min, running_max;
  logic [catavg_pkg::ERR_W-1:0] batch_error;

  logic signed [catavg_pkg::RES_W-1:0] out_res;
  logic [catavg_pkg::ERR_W-1:0]        out_err;
  logic                                out_valid;

  assign sample_in.ready      = (state == S_IDLE);
  assign result_out.valid     = out_valid;
  assign result_out.result_q16 = out_res;
  assign result_out.error_code = out_err;

  // shared multiplier: operands picked by mode and step
  logic signed [27:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [51:0] mul_p;
  logic               mul_last;

  always_comb begin
    mul_a = 28'sd0;
    mul_b = 24'sd0;
    mul_last = 1'b0;
    if (is_temp) begin
      unique case (step)
        2'd0: begin mul_a = $signed({16'd0, adc_q}); mul_b = 24'(r_word); end
        2'd1: begin mul_a = $signed({16'd0, temp_cal_low}); mul_b = $signed({12'd0, ref_q}); end
        2'd2: begin mul_a = t_a - t_b; mul_b = 24'(dt); end
        default: begin
          mul_a = $signed({16'd0, ref_q}); mul_b = 24'(span); mul_last = 1'b1;
        end
      endcase
    end else if (is_supply) begin
      if (step == 2'd0) begin
        mul_a = $signed({16'd0, cal_supply_mv}); mul_b = 24'(r_word);
      end else begin
        mul_a = $signed({16'd0, ref_q}); mul_b = 24'(catavg_pkg::MV_PER_V); mul_last = 1'b1;
      end
    end else begin
      unique case (step)
        2'd0: begin mul_a = $signed({16'd0, cal_supply_mv}); mul_b = 24'(r_word); end
        2'd1: begin mul_a = t_a; mul_b = $signed({12'd0, adc_q}); end
        default: begin
          mul_a = $signed({16'd0, ref_q}); mul_b = 24'(catavg_pkg::CHAN_SCALE);
          mul_last = 1'b1;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // destination of each product
  logic num_from_mul, den_from_mul, ta_from_mul, tb_from_mul;
  always_comb begin
    num_from_mul = 1'b0;
    den_from_mul = mul_last;
    ta_from_mul  = 1'b0;
    tb_from_mul  = 1'b0;
    if (is_temp) begin
      ta_from_mul  = (step == 2'd0);
      tb_from_mul  = (step == 2'd1);
      num_from_mul = (step == 2'd2);
    end else if (is_supply) begin
      num_from_mul = (step == 2'd0);
    end else begin
      ta_from_mul  = (step == 2'd0);
      num_from_mul = (step == 2'd1);
    end
  end

  // divider step
  logic [DDW:0]  rem_sh;
  logic          q_bit;
  logic [NW-1:0] n_mag;
  logic [DENW-1:0] d_mag;

  assign rem_sh = {rem, dvd[QW-1]};
  assign q_bit  = (rem_sh >= {1'b0, dsr});
  assign n_mag  = num[NW-1] ? NW'(-num) : NW'(num);
  assign d_mag  = den[DENW-1] ? DENW'(-den) : DENW'(den);

  // quotient sign, temperature offset and saturation
  logic signed [QW:0]   q_signed;
  logic signed [QW+1:0] q_total;
  logic signed [QW+1:0] t1_q16;

  assign q_signed = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  assign t1_q16   = (is_temp && !is_final)
                  ? ((QW + 2)'($signed(temp_point_low)) <<< 16) : '0;
  assign q_total  = (QW + 2)'(q_signed) + t1_q16;

  logic signed [31:0] sat_val;
  always_comb begin
    if (q_total > (QW + 2)'(32'sh7fffffff))      sat_val = 32'sh7fffffff;
    else if (q_total < -(QW + 2)'(33'sh080000000)) sat_val = 32'sh80000000;
    else                                          sat_val = q_total[31:0];
  end

  logic signed [41:0] rest;
  assign rest = 42'(running_sum) - 42'(running_min) - 42'(running_max);

  logic [CW-1:0] count_next;
  assign count_next = sample_count + CW'(1);

  logic out_load;
  assign out_load = (state == S_EMIT) && (!out_valid || result_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= 2'd0;
      div_cnt      <= '0;
      is_final     <= 1'b0;
      sample_count <= '0;
      running_sum  <= '0;
      running_min  <= 32'sh7fffffff;
      running_max  <= 32'sh80000000;
      batch_error  <= catavg_pkg::ERR_NONE;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (result_out.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (sample_in.valid) begin
            ref_q    <= sample_in.ref_reading;
            adc_q    <= sample_in.sample_reading;
            step     <= 2'd0;
            is_final <= 1'b0;
            // reference or span of zero: count the sample as zero
            if (sample_in.ref_reading == 12'd0) begin
              cur_err <= catavg_pkg::ERR_REF_ZERO;
              val     <= 32'sd0;
              state   <= S_ACC;
            end else if (is_temp && span == 13'sd0) begin
              cur_err <= catavg_pkg::ERR_SPAN_ZERO;
              val     <= 32'sd0;
              state   <= S_ACC;
            end else begin
              cur_err <= catavg_pkg::ERR_NONE;
              state   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (ta_from_mul)  t_a <= mul_p[27:0];
          if (tb_from_mul)  t_b <= mul_p[27:0];
          if (num_from_mul) num <= {mul_p[39:0], 16'd0};
          if (den_from_mul) den <= mul_p[DENW-1:0];
          step <= step + 2'd1;
          if (mul_last) state <= S_PREP;
        end
        S_PREP: begin
          // round to nearest: (2n + d) / (2d) on magnitudes
          dvd     <= {n_mag, 1'b0} + QW'(d_mag);
          dsr     <= {d_mag, 1'b0};
          rem     <= '0;
          neg     <= num[NW-1] ^ den[DENW-1];
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= q_bit ? DDW'(rem_sh - {1'b0, dsr}) : rem_sh[DDW-1:0];
          dvd     <= {dvd[QW-2:0], q_bit};
          div_cnt <= div_cnt + ICW'(1);
          if (div_cnt == ICW'(QW - 1)) state <= S_POST;
        end
        S_POST: begin
          val   <= sat_val;
          state <= is_final ? S_EMIT : S_ACC;
        end
        S_ACC: begin
          if (cur_err != catavg_pkg::ERR_NONE && batch_error == catavg_pkg::ERR_NONE)
            batch_error <= cur_err;
          running_sum  <= running_sum + 40'(val);
          if (val < running_min) running_min <= val;
          if (val > running_max) running_max <= val;
          sample_count <= count_next;
          state        <= (count_next == CW'(SAMPLES)) ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          // drop one minimum and one maximum, divide by the rest count
          is_final <= 1'b1;
          num      <= NW'(rest);
          den      <= DENW'(TRIM);
          if (batch_error != catavg_pkg::ERR_NONE) begin
            val   <= 32'sd0;
            state <= S_EMIT;
          end else begin
            state <= S_PREP;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (out_load) begin
            sample_count <= '0;
            running_sum  <= '0;
            running_min  <= 32'sh7fffffff;
            running_max  <= 32'sh80000000;
            batch_error  <= catavg_pkg::ERR_NONE;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= val;
      out_err <= batch_error;
    end
  end
endmodule
`default_nettype wire

[tb/sv/tb_calibrated_adc_trimmed_average_core.sv]
// Self-checking testbench for the calibrated converter trimmed-average core.
module tb_calibrated_adc_trimmed_average_core;
  timeunit 1ns;
  timeprecision 1ps;
  import catavg_pkg::*;

  localparam int SAMPLES = DEF_SAMPLES;
  localparam int SETTLE_CYCLES = 400;      // covers one pair plus a batch-end divide
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD_CYCLES = 900;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 125;

  // Register copy used for prediction.
  typedef struct {
    logic [1:0]         mode;
    logic [11:0]        ref_cal;
    logic signed [11:0] ref_offset;
    logic [11:0]        tcal_low;
    logic [11:0]        tcal_high;
    logic [11:0]        cal_mv;
    logic signed [8:0]  tpt_low;
    logic signed [8:0]  tpt_high;
  } cal_regs_t;

  typedef struct {
    logic signed [31:0] result_q16;
    logic [1:0]         error_code;
  } mean_t;

  // One directed row; the typed mean applies only on batch-closing rows.
  typedef struct {
    logic [11:0]        ref_reading;
    logic [11:0]        sample_reading;
    bit                 typed;
    logic signed [31:0] result_q16;
    logic [1:0]         error_code;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  catavg_in_if  pair_ch ();
  catavg_out_if mean_ch ();

  calibrated_adc_trimmed_average_core #(.SAMPLES(SAMPLES)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_in(pair_ch), .result_out(mean_ch)
  );

  // Predictor state: registers plus the batch accumulators.
  cal_regs_t cal;
  int unsigned batch_count;
  longint batch_sum;
  int batch_min;
  int batch_max;
  logic [1:0] batch_err;

  mean_t pending_means[$];
  int fail_count = 0;
  bit quiet_phase = 1'b0;       // no idling on either side
  bit long_hold_req = 1'b0;
  bit directed_typed = 1'b0;
  mean_t directed_mean;
  longint unsigned cycle_count = 0;

  pair_row_t pair_table[20];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic int clamp32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Convert one pair into its Q16 value under the current registers.
  function automatic void convert_pair(input logic [11:0] ref_rd, input logic [11:0] smp,
                                       output int val, output logic [1:0] err);
    longint rr, a, r, mv, span, t1, t2, num, den;
    rr = longint'(ref_rd);
    a = longint'(smp);
    r = longint'(cal.ref_cal) + longint'(cal.ref_offset);
    mv = longint'(cal.cal_mv);
    val = 0;
    err = ERR_NONE;
    if (rr == 0) begin
      err = ERR_REF_ZERO;
    end else if (cal.mode == MODE_TEMP) begin
      span = longint'(cal.tcal_high) - longint'(cal.tcal_low);
      if (span == 0) begin
        err = ERR_SPAN_ZERO;
      end else begin
        t1 = longint'(cal.tpt_low);
        t2 = longint'(cal.tpt_high);
        num = (t2 - t1) * (a * r - longint'(cal.tcal_low) * rr) * 65536;
        den = rr * span;
        if (den < 0) begin
          den = -den;
          num = -num;
        end
        val = clamp32(round_div(num, den) + t1 * 65536);
      end
    end else if (cal.mode == MODE_SUPPLY) begin
      val = clamp32(round_div(mv * r * 65536, longint'(MV_PER_V) * rr));
    end else begin
      // Mode three falls through to channel voltage.
      val = clamp32(round_div(mv * r * a * 65536, rr * longint'(CHAN_SCALE)));
    end
  endfunction

  function automatic void clear_batch();
    batch_count = 0;
    batch_sum = 0;
    batch_min = 32'sh7FFF_FFFF;
    batch_max = 32'sh8000_0000;
    batch_err = ERR_NONE;
  endfunction

  // Fold an accepted pair into the batch; queue the mean when the batch closes.
  function automatic void fold_pair(input logic [11:0] ref_rd, input logic [11:0] smp);
    int val;
    logic [1:0] err;
    mean_t m;
    convert_pair(ref_rd, smp, val, err);
    if (err != ERR_NONE && batch_err == ERR_NONE) batch_err = err;
    batch_sum += val;
    if (val < batch_min) batch_min = val;
    if (val > batch_max) batch_max = val;
    batch_count++;
    if (batch_count < SAMPLES) return;
    m.error_code = batch_err;
    m.result_q16 = (batch_err != ERR_NONE) ? 0 :
      clamp32(round_div(batch_sum - longint'(batch_min) - longint'(batch_max),
                        longint'(SAMPLES - 2)));
    pending_means.push_back(directed_typed ? directed_mean : m);
    clear_batch();
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write every register and mirror it; only called while the block is idle.
  task automatic load_regs(input cal_regs_t c);
    reg_write(REG_MODE, 32'(c.mode));
    reg_write(REG_REF_CAL, 32'(c.ref_cal));
    reg_write(REG_REF_OFFSET, 32'(unsigned'(c.ref_offset)));
    reg_write(REG_TCAL_LOW, 32'(c.tcal_low));
    reg_write(REG_TCAL_HIGH, 32'(c.tcal_high));
    reg_write(REG_CAL_MV, 32'(c.cal_mv));
    reg_write(REG_TPT_LOW, 32'(unsigned'(c.tpt_low)));
    reg_write(REG_TPT_HIGH, 32'(unsigned'(c.tpt_high)));
    cal = c;
  endtask

  // Offer one pair after a random gap; fold it into the predictor on acceptance.
  task automatic send_pair(input logic [11:0] ref_rd, input logic [11:0] smp);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      pair_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair_ch.valid <= 1'b1;
    pair_ch.ref_reading <= ref_rd;
    pair_ch.sample_reading <= smp;
    do @(posedge clk); while (!pair_ch.ready);
    fold_pair(ref_rd, smp);
  endtask

  // Hold the sender until every queued mean has drained, then let the core settle.
  task automatic drain_and_settle();
    pair_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_reading();
    case ($urandom_range(0, 19))
      0:       return 12'd0;
      1:       return 12'd1;
      2:       return 12'hFFF;
      3, 4, 5: return 12'($urandom_range(1200, 2200));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic cal_regs_t pick_regs();
    cal_regs_t c;
    c.mode = 2'($urandom_range(0, 3));
    c.ref_cal = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(1500, 1800));
    c.ref_offset = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(0, 60));
    c.tcal_low = 12'($urandom);
    // Equal calibration points now and then to reach the zero-span error.
    c.tcal_high = ($urandom_range(0, 4) == 0) ? c.tcal_low : 12'($urandom);
    c.cal_mv = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(1000, 3600));
    c.tpt_low = 9'($urandom);
    c.tpt_high = 9'($urandom);
    return c;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    mean_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold_req) begin
        mean_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end
      stall = quiet_phase ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        mean_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      mean_ch.ready <= 1'b1;
      do @(posedge clk); while (!mean_ch.valid);
    end
  end

  // Compare each result transaction with the oldest expected mean.
  always @(posedge clk) begin
    mean_t want;
    if (!rst && mean_ch.valid && mean_ch.ready) begin
      if (pending_means.size() == 0) begin
        $error("unexpected result: result_q16=%0d error_code=%0d",
               mean_ch.result_q16, mean_ch.error_code);
        fail_count++;
      end else begin
        want = pending_means.pop_front();
        if (mean_ch.result_q16 !== want.result_q16) begin
          $error("result_q16 mismatch: expected %0d actual %0d",
                 want.result_q16, mean_ch.result_q16);
          fail_count++;
        end
        if (mean_ch.error_code !== want.error_code) begin
          $error("error_code mismatch: expected %0d actual %0d",
                 want.error_code, mean_ch.error_code);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cal_regs_t c;
    // Directed pairs under reset registers (temperature mode).
    // Batch 1: zero reference first, so the batch reports the reference error.
    pair_table[0]  = '{12'd0,    12'd100,  1'b0, 0, ERR_NONE};
    pair_table[1]  = '{12'd1671, 12'd700,  1'b0, 0, ERR_NONE};
    pair_table[2]  = '{12'd1671, 12'd800,  1'b0, 0, ERR_NONE};
    pair_table[3]  = '{12'd1671, 12'd900,  1'b0, 0, ERR_NONE};
    pair_table[4]  = '{12'd1671, 12'd1000, 1'b1, 0, ERR_REF_ZERO};
    // Batch 2: field extremes, checked against the predictor.
    pair_table[5]  = '{12'hFFF,  12'd0,    1'b0, 0, ERR_NONE};
    pair_table[6]  = '{12'hFFF,  12'hFFF,  1'b0, 0, ERR_NONE};
    pair_table[7]  = '{12'd1,    12'hFFF,  1'b0, 0, ERR_NONE};
    pair_table[8]  = '{12'd1,    12'd0,    1'b0, 0, ERR_NONE};
    pair_table[9]  = '{12'd2048, 12'd2048, 1'b0, 0, ERR_NONE};
    // Batch 3: every value saturates high, so the mean is the top of the range.
    pair_table[10] = '{12'd1,    12'hFFF,  1'b0, 0, ERR_NONE};
    pair_table[11] = '{12'd1,    12'hFFF,  1'b0, 0, ERR_NONE};
    pair_table[12] = '{12'd1,    12'hFFF,  1'b0, 0, ERR_NONE};
    pair_table[13] = '{12'd1,    12'hFFF,  1'b0, 0, ERR_NONE};
    pair_table[14] = '{12'd1,    12'hFFF,  1'b1, 32'sh7FFF_FFFF, ERR_NONE};
    // Batch 4: a zero reference on the last pair still flags the batch.
    pair_table[15] = '{12'hFFF,  12'hFFF,  1'b0, 0, ERR_NONE};
    pair_table[16] = '{12'd1650, 12'd760,  1'b0, 0, ERR_NONE};
    pair_table[17] = '{12'd1700, 12'd640,  1'b0, 0, ERR_NONE};
    pair_table[18] = '{12'd1671, 12'd860,  1'b0, 0, ERR_NONE};
    pair_table[19] = '{12'd0,    12'hFFF,  1'b1, 0, ERR_REF_ZERO};

    pair_ch.valid = 1'b0;
    pair_ch.ref_reading = '0;
    pair_ch.sample_reading = '0;
    cal = '{RST_MODE, RST_REF_CAL, RST_REF_OFFSET, RST_TCAL_LOW, RST_TCAL_HIGH,
            RST_CAL_MV, RST_TPT_LOW, RST_TPT_HIGH};
    clear_batch();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (pair_table[i]) begin
      directed_typed = pair_table[i].typed;
      directed_mean.result_q16 = pair_table[i].result_q16;
      directed_mean.error_code = pair_table[i].error_code;
      send_pair(pair_table[i].ref_reading, pair_table[i].sample_reading);
      directed_typed = 1'b0;
    end
    drain_and_settle();

    // Random phases; the first two use the register extremes.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       c = '{2'd3, 12'hFFF, 12'sd2047, 12'd0, 12'hFFF, 12'd3600, 9'sd150, -9'sd40};
        1:       c = '{2'd0, 12'd0, -12'sd2048, 12'hFFF, 12'd0, 12'd1000, -9'sd40, 9'sd150};
        2:       c = '{2'd1, 12'd1671, 12'sd0, 12'd670, 12'd860, 12'd3000, 9'sd30, 9'sd130};
        default: c = pick_regs();
      endcase
      load_regs(c);
      quiet_phase = (ph == 4 || ph == 7);
      if (ph == 3) long_hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) send_pair(pick_reading(), pick_reading());
      quiet_phase = 1'b0;
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
